// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/bmsls_pkg.sv -----
// types, codes and helpers of the byte-addressed load/store memory
package bmsls_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    W_BYTE   = 3'b000,
    W_HALF   = 3'b001,
    W_WORD   = 3'b010,
    W_BYTE_U = 3'b100,
    W_HALF_U = 3'b101
  } width_e;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [2:0]  width_code;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               access_error;
  } out_t;

  typedef struct packed {
    logic we;
    logic re;
  } bank_ctl_t;

  // bytes touched by an access, zero for a code the op does not support
  function automatic logic [2:0] access_size(logic is_write, logic [2:0] code);
    logic [2:0] n;
    n = 3'd0;
    if (is_write) begin
      case (code)
        W_BYTE:  n = 3'd1;
        W_HALF:  n = 3'd2;
        W_WORD:  n = 3'd4;
        default: n = 3'd0;
      endcase
    end else begin
      case (code)
        W_BYTE, W_BYTE_U: n = 3'd1;
        W_HALF, W_HALF_U: n = 3'd2;
        W_WORD:           n = 3'd4;
        default:          n = 3'd0;
      endcase
    end
    return n;
  endfunction

endpackage

// ----- rtl/bmsls_bank.sv -----
// one byte-lane bank: single-port synchronous ram with registered read
module bmsls_bank #(
  parameter int unsigned DEPTH = bmsls_pkg::MEM_BYTES_DEF / 4,
  parameter int unsigned ROW_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  bmsls_pkg::bank_ctl_t  ctl_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [7:0]            wdata_i,
  output logic [7:0]            rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[row_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[row_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/byte_memory_sized_load_store.sv -----
// top level of the byte-addressed little-endian load/store memory
// The block is a little-endian byte memory of MEM_BYTES bytes serving one
// load or store per beat. It takes a new access every cycle while the result
// side keeps up; a load result is held first in stage one, where the four
// byte-lane banks deliver their registered read data, then in the output
// register, and a store or rejected access passes the same registers.
// Any 1, 2 or 4 byte access, aligned or not, is served in a single bank access
// because each byte of it falls in a different bank. After reset the banks
// are swept to zero, one row of four bytes a cycle over all (MEM_BYTES+3)/4
// rows (16384 at the default size), with in_stall_o held high for the sweep.
// Unsupported width codes and accesses reaching past MEM_BYTES return
// access_error with read_data zero and leave the memory untouched.
module byte_memory_sized_load_store #(
  parameter int unsigned MEM_BYTES = bmsls_pkg::MEM_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bmsls_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bmsls_pkg::out_t  out_data_o
);

  localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // clearing sweep after reset
  logic             clearing_q, clearing_d;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;

  // access decode
  logic        accept;
  logic [2:0]  size;
  logic [32:0] end_addr;
  logic        ok;
  logic        is_write;
  logic [1:0]  off;

  // stage one: bank read data is valid here
  logic       s1_valid_q, s1_valid_d;
  logic       s1_move;
  logic       s1_err_q;
  logic       s1_rd_q;
  logic       s1_signed_q;
  logic [2:0] s1_size_q;
  logic [1:0] s1_off_q;

  // output register
  logic            out_valid_q, out_valid_d;
  bmsls_pkg::out_t out_q;
  bmsls_pkg::out_t s1_result;

  logic [7:0] rdata [4];

  assign is_write = (in_data_i.op == bmsls_pkg::OP_WRITE);
  assign off      = in_data_i.address[1:0];
  assign size     = bmsls_pkg::access_size(in_data_i.op, in_data_i.width_code);
  // no wrap: the end of the access is checked in 33 bits
  assign end_addr = {1'b0, in_data_i.address} + 33'(size);
  assign ok       = (size != 3'd0) && (end_addr <= 33'(MEM_BYTES));

  // stage one drains when the output register is empty or being taken
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = clearing_q || (s1_valid_q && !s1_move);
  assign accept     = in_valid_i && !in_stall_o;

  // four byte lanes; lane k holds bytes whose address is k mod 4
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]           lane_idx;
    logic                 lane_en;
    logic [ROW_W-1:0]     lane_row;
    logic [7:0]           lane_wdata;
    bmsls_pkg::bank_ctl_t lane_ctl;
    logic [ROW_W-1:0]     bank_row;
    logic [7:0]           bank_wdata;

    // position of this lane's byte inside the access
    assign lane_idx   = 2'(k) - off;
    assign lane_en    = ({1'b0, lane_idx} < size);
    // lanes below the start offset wrap into the next row
    assign lane_row   = ROW_W'(in_data_i.address[31:2]) + ROW_W'(2'(k) < off);
    assign lane_wdata = in_data_i.write_data[{lane_idx, 3'b000} +: 8];

    assign lane_ctl.we = clearing_q || (accept && ok && is_write && lane_en);
    assign lane_ctl.re = !clearing_q && accept && ok && !is_write && lane_en;
    assign bank_row    = clearing_q ? clr_row_q : lane_row;
    assign bank_wdata  = clearing_q ? 8'h00 : lane_wdata;

    bmsls_bank #(
      .DEPTH (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i   (clk_i),
      .ctl_i   (lane_ctl),
      .row_i   (bank_row),
      .wdata_i (bank_wdata),
      .rdata_o (rdata[k])
    );
  end

  // clear sweep control
  always_comb begin
    clearing_d = clearing_q;
    clr_row_d  = clr_row_q;
    if (clearing_q) begin
      if (clr_row_q == ROW_W'(ROWS - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_row_d = clr_row_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (s1_valid_q && s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // gather bytes in access order and extend
  always_comb begin
    logic [7:0] b [4];
    logic [31:0] value;
    for (int i = 0; i < 4; i++) begin
      b[i] = rdata[2'(s1_off_q + 2'(i))];
    end
    case (s1_size_q)
      3'd1:    value = {{24{s1_signed_q & b[0][7]}}, b[0]};
      3'd2:    value = {{16{s1_signed_q & b[1][7]}}, b[1], b[0]};
      3'd4:    value = {b[3], b[2], b[1], b[0]};
      default: value = 32'd0;
    endcase
    s1_result.read_data    = (s1_rd_q && !s1_err_q) ? value : 32'sd0;
    s1_result.access_error = s1_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_row_q   <= clr_row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_err_q    <= !ok;
      s1_rd_q     <= !is_write;
      s1_signed_q <= !in_data_i.width_code[2];
      s1_size_q   <= size;
      s1_off_q    <= off;
    end
    if (s1_valid_q && s1_move) begin
      out_q <= s1_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/bmsls_checker.sv -----
// port-level checker for the load/store memory, bound to the top level
`include "assert_macros.svh"

module bmsls_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input bmsls_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input bmsls_pkg::out_t out_data_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // a stalled result does not change
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  // an accepted beat reaches the output when the output side keeps up
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, in_beat ##1 !out_stall_i, out_valid_o)
  // a fresh result always traces back to an input beat through stage one
  `ASSERT_IMPLIES(a_no_invent, clk_i, rst_ni, $rose(out_valid_o), $past(in_beat, 2))

endmodule

bind byte_memory_sized_load_store bmsls_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/byte_memory_sized_load_store_tb.sv -----
// testbench for the byte-addressed little-endian load/store memory
`timescale 1ns / 1ps

module byte_memory_sized_load_store_tb;

  localparam int unsigned MEM_BYTES = bmsls_pkg::MEM_BYTES_DEF;
  // width codes with no member in width_e: all of them are rejected on reads
  // and writes alike, along with the unsigned codes on writes
  localparam logic [2:0] W_DWORD  = 3'b011;
  localparam logic [2:0] W_WORD_U = 3'b110;
  localparam logic [2:0] W_RSVD   = 3'b111;
  localparam int unsigned RAND_BEATS  = 600;
  localparam int unsigned LONG_HOLD   = 400;  // receiver hold-off, in cycles
  localparam int unsigned HOLD_AT     = 200;  // input beats before that hold-off
  localparam int unsigned TAIL_CYCLES = 20;   // settle time after the last result
  // the reset sweep covers 16384 rows; the limit is well past a slow run
  localparam longint unsigned WATCHDOG_NS = 64'd4_000_000;

  // an access waiting to be sent; drain_first holds it back until every
  // earlier access has returned its result
  typedef struct {
    bmsls_pkg::in_t beat;
    bit             drain_first;
  } access_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  bmsls_pkg::in_t  in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  bmsls_pkg::out_t out_data_o;

  access_t         access_q[$];           // stimulus not yet offered
  bmsls_pkg::out_t pending_results_q[$];  // predicted results, oldest first
  bit [7:0]        mem_shadow [MEM_BYTES];  // zero at start, like the swept banks
  int unsigned     beats_in   = 0;
  int unsigned     fault_cnt  = 0;
  int unsigned     gap_cnt    = 0;
  int unsigned     burst_left = 0;

  byte_memory_sized_load_store #(
    .MEM_BYTES(MEM_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // applies one access to the shadow memory and returns the result it owes
  function automatic bmsls_pkg::out_t predict_access(bmsls_pkg::in_t a);
    bmsls_pkg::out_t r;
    int unsigned     nbytes;
    logic [31:0]     val;
    longint unsigned reach;
    r      = '0;
    val    = '0;
    nbytes = 0;
    case (a.width_code)
      bmsls_pkg::W_BYTE:   nbytes = 1;
      bmsls_pkg::W_HALF:   nbytes = 2;
      bmsls_pkg::W_WORD:   nbytes = 4;
      // unsigned loads exist only as reads
      bmsls_pkg::W_BYTE_U: nbytes = (a.op == bmsls_pkg::OP_WRITE) ? 0 : 1;
      bmsls_pkg::W_HALF_U: nbytes = (a.op == bmsls_pkg::OP_WRITE) ? 0 : 2;
      default:             nbytes = 0;
    endcase
    // 64-bit sum so an address near the top of the 32-bit space cannot wrap
    reach = {32'd0, a.address} + 64'(nbytes);
    if (nbytes == 0 || reach > 64'(MEM_BYTES)) begin
      r.access_error = 1'b1;
      return r;
    end
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (a.op == bmsls_pkg::OP_WRITE) begin
        mem_shadow[a.address + i] = a.write_data[8*i +: 8];
      end else begin
        val[8*i +: 8] = mem_shadow[a.address + i];
      end
    end
    // signed byte and half loads extend from their top bit
    if (a.op == bmsls_pkg::OP_READ && !a.width_code[2]) begin
      if (nbytes == 1) begin
        val = {{24{val[7]}}, val[7:0]};
      end else if (nbytes == 2) begin
        val = {{16{val[15]}}, val[15:0]};
      end
    end
    r.read_data = val;
    return r;
  endfunction

  function automatic void queue_access(bmsls_pkg::op_e op, logic [31:0] addr,
                                       logic [2:0] code, logic [31:0] data,
                                       bit drain_first = 1'b0);
    access_t t;
    t.beat.op         = op;
    t.beat.address    = addr;
    t.beat.width_code = code;
    t.beat.write_data = data;
    t.drain_first     = drain_first;
    access_q.push_back(t);
  endfunction

  task automatic note_fault(string what, logic [31:0] want, logic [31:0] got);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // driver: a beat leaves at an edge where valid is high and stall is low;
  // the next one is put up at that same edge when no gap is due, so valid
  // only falls after an accepted beat or stays low through a gap or a drain
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bit          busy;
    int unsigned gap;
    int unsigned roll;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      busy = in_valid_i;
      gap  = gap_cnt;
      if (in_valid_i && !in_stall_o) begin
        pending_results_q.push_back(predict_access(in_data_i));
        beats_in <= beats_in + 1;
        busy = 1'b0;
        // mostly back-to-back or short gaps, a few long ones, and now and
        // then a burst of beats with no gap at all
        if (burst_left != 0) begin
          burst_left--;
          gap = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
          end else if (roll < 50) begin
            gap = 0;
          end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
          end else begin
            gap = $urandom_range(10, 30);
          end
        end
      end
      if (!busy) begin
        if (gap != 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (access_q.size() != 0 &&
                     (!access_q[0].drain_first || pending_results_q.size() == 0)) begin
          in_data_i  <= access_q[0].beat;
          in_valid_i <= 1'b1;
          access_q.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      gap_cnt <= gap;
    end
  end

  // result-side stall: random holds and free stretches, plus one long
  // hold-off once enough beats went in, so the block fills and pushes back
  always @(posedge clk_i or negedge rst_ni) begin : backpressure
    int unsigned hold_left;
    int unsigned free_left;
    bit          long_done;
    int unsigned roll;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      free_left = 0;
      long_done = 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!long_done && beats_in >= HOLD_AT) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (free_left != 0) begin
      out_stall_i <= 1'b0;
      free_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall_i <= 1'b0;
        free_left = $urandom_range(0, 6);
      end else if (roll < 88) begin
        out_stall_i <= 1'b1;
        hold_left = $urandom_range(0, 2);
      end else if (roll < 96) begin
        out_stall_i <= 1'b1;
        hold_left = $urandom_range(8, 30);
      end else begin
        out_stall_i <= 1'b0;
        free_left = $urandom_range(40, 120);
      end
    end
  end

  // checker samples mid-cycle: valid, stall and data are settled there and
  // hold the values the next rising edge will take
  always @(negedge clk_i) begin : scoreboard
    bmsls_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results_q.size() == 0) begin
        note_fault("result beat with no access outstanding", '0, out_data_o.read_data);
      end else begin
        want = pending_results_q.pop_front();
        if (out_data_o.read_data !== want.read_data) begin
          note_fault("read_data", want.read_data, out_data_o.read_data);
        end
        if (out_data_o.access_error !== want.access_error) begin
          note_fault("access_error", 32'(want.access_error), 32'(out_data_o.access_error));
        end
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  legal_codes [5];
    logic [31:0] addr;
    logic [2:0]  code;
    int unsigned roll;
    legal_codes = '{bmsls_pkg::W_BYTE, bmsls_pkg::W_HALF, bmsls_pkg::W_WORD,
                    bmsls_pkg::W_BYTE_U, bmsls_pkg::W_HALF_U};

    // lane order and extension: bytes 01 7f ff 80 from address 0 upward
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, bmsls_pkg::W_WORD,   32'h80FF_7F01);
    queue_access(bmsls_pkg::OP_READ,  32'd0, bmsls_pkg::W_BYTE,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd1, bmsls_pkg::W_BYTE,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd2, bmsls_pkg::W_BYTE,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd3, bmsls_pkg::W_BYTE_U, 32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd1, bmsls_pkg::W_HALF,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd2, bmsls_pkg::W_HALF_U, 32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd0, bmsls_pkg::W_WORD,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd1, bmsls_pkg::W_WORD,   32'h0);
    // top edge of the store: last word fits, one byte further does not
    queue_access(bmsls_pkg::OP_WRITE, MEM_BYTES - 4, bmsls_pkg::W_WORD,   32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_READ,  MEM_BYTES - 4, bmsls_pkg::W_WORD,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  MEM_BYTES - 3, bmsls_pkg::W_WORD,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  MEM_BYTES - 1, bmsls_pkg::W_BYTE,   32'h0);
    queue_access(bmsls_pkg::OP_READ,  MEM_BYTES - 1, bmsls_pkg::W_HALF_U, 32'h0);
    // no wrap past the top of the address space
    queue_access(bmsls_pkg::OP_READ,  32'hFFFF_FFFF, bmsls_pkg::W_BYTE_U, 32'h0);
    queue_access(bmsls_pkg::OP_WRITE, 32'hFFFF_FFFE, bmsls_pkg::W_HALF,   32'h0);
    // unsupported loads, the 64-bit and 32-bit-unsigned ones among them
    queue_access(bmsls_pkg::OP_READ,  32'd0, W_DWORD,  32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd0, W_WORD_U, 32'h0);
    queue_access(bmsls_pkg::OP_READ,  32'd0, W_RSVD,   32'h0);
    // unsupported stores must leave address 0 untouched
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, W_DWORD,             32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, bmsls_pkg::W_BYTE_U, 32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, bmsls_pkg::W_HALF_U, 32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, W_WORD_U,            32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_WRITE, 32'd0, W_RSVD,              32'hFFFF_FFFF);
    queue_access(bmsls_pkg::OP_READ,  32'd0, bmsls_pkg::W_WORD,   32'h0);

    // random traffic: mostly a small window so loads see earlier stores,
    // some anywhere in the store, some at the top edge, some wild addresses;
    // two points in the run wait for every result before going on
    for (int k = 0; k < RAND_BEATS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        addr = $urandom_range(0, 63);
      end else if (roll < 75) begin
        addr = $urandom_range(0, MEM_BYTES - 1);
      end else if (roll < 87) begin
        addr = MEM_BYTES - $urandom_range(1, 8);
      end else begin
        addr = $urandom();
      end
      if ($urandom_range(0, 99) < 85) begin
        code = legal_codes[$urandom_range(0, 4)];
      end else begin
        code = 3'($urandom_range(0, 7));
      end
      queue_access(bmsls_pkg::op_e'($urandom_range(0, 1)), addr, code, $urandom(),
                   k == 0 || k == 400);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and every result back, then a short settle
    while (access_q.size() != 0 || in_valid_i || pending_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0 && pending_results_q.size() == 0) begin
      $display("byte_memory_sized_load_store_tb: done, clean");
    end else begin
      $display("byte_memory_sized_load_store_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("byte_memory_sized_load_store_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bmsls_pkg.sv
rtl/bmsls_bank.sv
rtl/byte_memory_sized_load_store.sv
rtl/bmsls_checker.sv
test/byte_memory_sized_load_store_tb.sv
